[hdl/stl_pkg.sv]
// Shared types and constants for the shell token lexer.
// Used by the lexer step, the result emitter and the top level.
package stl_pkg;

  localparam int MAX_RES = 4;
  localparam int IDX_W   = $clog2(MAX_RES);
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  localparam logic [1:0] KIND_WORD  = 2'd0;
  localparam logic [1:0] KIND_REDIR = 2'd1;
  localparam logic [1:0] KIND_PIPE  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  // One result: a token character or an end marker.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       tok_end;
  } res_t;

  // All results caused by one input byte, entry 0 first.
  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]   cnt;
  } res_list_t;

endpackage

[hdl/stl_if.sv]
// Valid/ready channel interfaces for the lexer byte input and result output.
// Stand-alone; no package dependency.
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

interface stl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] out_char;
  logic       is_token_end;
  logic       run_last;

  modport source (output valid, output token_kind, output out_char,
                  output is_token_end, output run_last, input ready);
  modport sink   (input valid, input token_kind, input out_char,
                  input is_token_end, input run_last, output ready);
endinterface

[hdl/stl_lexer.sv]
// Lexer state and per-byte step logic: produces the result list of one byte.
// Depends on stl_pkg.
module stl_lexer import stl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  input  logic       is_final,
  output res_list_t  lst
);

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_DIGIT = 3'd1,
    M_REDIR = 3'd2,
    M_WORD  = 3'd3,
    M_QUOTE = 3'd4,
    M_DEAD  = 3'd5
  } lex_mode_t;

  typedef struct packed {
    res_list_t  lst;
    lex_mode_t  mode;
    logic [7:0] digit;
  } step_t;

  lex_mode_t  mode_r, mode_nxt;
  logic [7:0] digit_r, digit_nxt;
  step_t      st;

  function automatic logic is_ws(logic [7:0] b);
    return (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE;
  endfunction

  function automatic step_t push(step_t s, logic [1:0] k, logic [7:0] c, logic e);
    step_t r;
    r = s;
    if (s.lst.cnt < CNT_W'(MAX_RES)) begin
      r.lst.ent[s.lst.cnt[IDX_W-1:0]].kind    = k;
      r.lst.ent[s.lst.cnt[IDX_W-1:0]].ch      = e ? CH_NUL : c;
      r.lst.ent[s.lst.cnt[IDX_W-1:0]].tok_end = e;
      r.lst.cnt = s.lst.cnt + CNT_W'(1);
    end
    return r;
  endfunction

  function automatic step_t start_token(step_t s, logic [7:0] b);
    step_t r;
    r = s;
    if (is_ws(b)) begin
      r.mode = M_IDLE;
    end else if (b == CH_NUL) begin
      r.mode = M_DEAD;
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      r.digit = b;
      r.mode  = M_DIGIT;
    end else if (b == CH_GT) begin
      r      = push(r, KIND_REDIR, b, 1'b0);
      r.mode = M_REDIR;
    end else if (b == CH_PIPE) begin
      r      = push(r, KIND_PIPE, b, 1'b0);
      r      = push(r, KIND_PIPE, CH_NUL, 1'b1);
      r.mode = M_IDLE;
    end else if (b == CH_QUOTE) begin
      r.mode = M_QUOTE;
    end else begin
      r      = push(r, KIND_WORD, b, 1'b0);
      r.mode = M_WORD;
    end
    return r;
  endfunction

  function automatic step_t word_byte(step_t s, logic [7:0] b);
    step_t r;
    r = s;
    if (is_ws(b)) begin
      r      = push(r, KIND_WORD, CH_NUL, 1'b1);
      r.mode = M_IDLE;
    end else if (b == CH_NUL) begin
      r      = push(r, KIND_WORD, CH_NUL, 1'b1);
      r.mode = M_DEAD;
    end else if (b == CH_GT || b == CH_PIPE) begin
      r = push(r, KIND_WORD, CH_NUL, 1'b1);
      r = start_token(r, b);
    end else begin
      r      = push(r, KIND_WORD, b, 1'b0);
      r.mode = M_WORD;
    end
    return r;
  endfunction

  function automatic step_t close_open(step_t s);
    step_t r;
    r = s;
    case (s.mode)
      M_DIGIT: begin
        r = push(r, KIND_WORD, s.digit, 1'b0);
        r = push(r, KIND_WORD, CH_NUL, 1'b1);
      end
      M_REDIR: r = push(r, KIND_REDIR, CH_NUL, 1'b1);
      M_WORD, M_QUOTE: r = push(r, KIND_WORD, CH_NUL, 1'b1);
      default: ;
    endcase
    r.mode = M_IDLE;
    return r;
  endfunction

  always_comb begin
    st = '{lst: '0, mode: mode_r, digit: digit_r};
    unique case (mode_r)
      M_DEAD: ;
      M_DIGIT: begin
        if (in_byte == CH_GT) begin
          st      = push(st, KIND_REDIR, digit_r, 1'b0);
          st      = push(st, KIND_REDIR, in_byte, 1'b0);
          st.mode = M_REDIR;
        end else begin
          st = push(st, KIND_WORD, digit_r, 1'b0);
          st = word_byte(st, in_byte);
        end
      end
      M_REDIR: begin
        if (in_byte == CH_GT) begin
          st      = push(st, KIND_REDIR, in_byte, 1'b0);
          st      = push(st, KIND_REDIR, CH_NUL, 1'b1);
          st.mode = M_IDLE;
        end else begin
          st = push(st, KIND_REDIR, CH_NUL, 1'b1);
          st = start_token(st, in_byte);
        end
      end
      M_WORD: st = word_byte(st, in_byte);
      M_QUOTE: begin
        if (in_byte == CH_QUOTE) begin
          st      = push(st, KIND_WORD, CH_NUL, 1'b1);
          st.mode = M_IDLE;
        end else if (in_byte == CH_NUL) begin
          st      = push(st, KIND_WORD, CH_NUL, 1'b1);
          st.mode = M_DEAD;
        end else begin
          st = push(st, KIND_WORD, in_byte, 1'b0);
        end
      end
      default: st = start_token(st, in_byte);
    endcase
    if (is_final) begin
      st = close_open(st);
    end
    lst       = st.lst;
    mode_nxt  = st.mode;
    digit_nxt = st.digit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      digit_r <= 8'h00;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      digit_r <= digit_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    lst.cnt <= CNT_W'(MAX_RES))
    else $error("lexer result count out of range");
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(mode_r) && $stable(digit_r))
    else $error("lexer state moved without a beat");
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_final |=> mode_r == M_IDLE)
    else $error("lexer not idle after final byte");
`endif

endmodule

[hdl/stl_emit.sv]
// Result buffer: holds the results of one byte and hands them out one per beat.
// Depends on stl_pkg and stl_out_if.
module stl_emit import stl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  res_list_t lst,
  output logic      can_load,
  stl_out_if.source out_chan
);

  res_t [MAX_RES-1:0] ent_r, ent_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pop;

  assign pop      = (cnt_r != '0) && out_chan.ready;
  // Free for a new byte when empty, or once the last pending result leaves this cycle.
  assign can_load = (cnt_r == '0) || (cnt_r == CNT_W'(1) && out_chan.ready);

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (load && lst.cnt != '0) begin
      ent_nxt = lst.ent;
      cnt_nxt = lst.cnt;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign out_chan.valid        = cnt_r != '0;
  assign out_chan.token_kind   = ent_r[0].kind;
  assign out_chan.out_char     = ent_r[0].ch;
  assign out_chan.is_token_end = ent_r[0].tok_end;
  assign out_chan.run_last     = cnt_r == CNT_W'(1);

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load && lst.cnt != '0 |-> cnt_r == '0 || (cnt_r == CNT_W'(1) && pop))
    else $error("result buffer overwritten");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RES))
    else $error("result buffer count out of range");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    pop && cnt_r > CNT_W'(1) |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("result buffer count not decremented on pop");
`endif

endmodule

[hdl/shell_token_lexer_core.sv]
// Shell token lexer top level: byte channel in, token result channel out.
// Latency: first result of a byte is presented the cycle after its beat.
// Throughput: one byte per cycle while each byte yields at most one result and the output is ready;
// a byte yielding n results holds the output buffer for n result beats.
// Reset (synchronous, rst_n low): lexer idle, held digit zero, buffer empty.
// Depends on stl_pkg, stl_if, stl_lexer and stl_emit.
module shell_token_lexer_core import stl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  stl_in_if.sink    in_chan,
  stl_out_if.source out_chan
);

  res_list_t lst;
  logic      in_fire;
  logic      can_load;

  assign in_chan.ready = can_load;
  assign in_fire       = in_chan.valid && can_load;

  stl_lexer u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_byte  (in_chan.in_byte),
    .is_final (in_chan.is_final),
    .lst      (lst)
  );

  stl_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_fire),
    .lst      (lst),
    .can_load (can_load),
    .out_chan (out_chan)
  );

endmodule
